FILE: rtl/core/rcdc_pkg.sv
package rcdc_pkg;

  // Channel and stream geometry
  localparam int CHANNEL_BITS = 11;
  localparam int NUM_CH       = 6;
  localparam int S_TDATA_W    = ((NUM_CH * CHANNEL_BITS + 7) / 8) * 8;

  localparam int CH_THR  = 0;
  localparam int CH_STR  = 1;
  localparam int CH_RAT  = 2;
  localparam int CH_SL   = 3;
  localparam int CH_SR   = 4;
  localparam int CH_MODE = 5;

  // Result fields
  localparam int THR_W      = 16;
  localparam int STR_W      = 18;
  localparam int BRAKE_W    = 16;
  localparam int MODE_W     = 2;
  localparam int M_FIELDS_W = THR_W + STR_W + BRAKE_W + 1 + MODE_W;
  localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

  // Configuration registers
  localparam int MAX_STEER_W = 15;
  localparam int MIN_STEER_W = 16;
  localparam int PADDR_W     = 4;
  localparam int PDATA_W     = 32;

  localparam logic [1:0] REG_MAX_STEER = 2'd0;
  localparam logic [1:0] REG_MIN_STEER = 2'd1;
  localparam logic [1:0] REG_E_BRAKE   = 2'd2;

  localparam logic [MAX_STEER_W-1:0] MAX_STEER_RST = MAX_STEER_W'(6400);
  localparam logic [MIN_STEER_W-1:0] MIN_STEER_RST = MIN_STEER_W'(-6400);
  localparam logic [BRAKE_W-1:0]     E_BRAKE_RST   = BRAKE_W'(65535);

  // Drive modes
  localparam logic [MODE_W-1:0] MODE_AUTO     = 2'd0;
  localparam logic [MODE_W-1:0] MODE_OVERRIDE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_MANUAL   = 2'd2;

  // Centred channel values span -818..808
  localparam int D_W    = 11;
  localparam int CH_MAX = 1800;
  localparam int CH_MIN = 174;
  localparam int CH_MID = 992;

  localparam logic signed [D_W-1:0] D_BAND_HI = D_W'(40);
  localparam logic signed [D_W-1:0] D_BAND_LO = D_W'(-40);
  localparam logic signed [D_W-1:0] D_MODE_HI = D_W'(404);
  localparam logic signed [D_W-1:0] D_MODE_LO = D_W'(-409);

  // Q1.15 normalization by reciprocal multiply and one correction step
  localparam int Q_FRAC      = 15;
  localparam int NUM_W       = D_W - 1 + Q_FRAC;
  localparam int DIV_POS     = 808;
  localparam int DIV_NEG     = 818;
  localparam int BIAS_POS    = 404;
  localparam int BIAS_NEG    = 409;
  localparam int RECIP_SHIFT = NUM_W;
  localparam int RECIP_POS   = (1 << RECIP_SHIFT) / DIV_POS;
  localparam int RECIP_NEG   = (1 << RECIP_SHIFT) / DIV_NEG;
  localparam int Q_W         = 17;
  localparam int N_W         = 16;
  localparam int MAG_W       = N_W + 1;

  // Shared multiplier
  localparam int MUL_A_W = 31;
  localparam int MUL_B_W = 27;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  // Angle and radian conversion
  localparam int ANG_W     = 33;
  localparam int X10_W     = MUL_A_W + 4;
  localparam int DZ_LIMIT  = 1 << 23;
  localparam int DEG2RAD_K = 74961321;
  localparam int RAD_SHIFT = 39;
  localparam int RQ_W      = PROD_W + 1 - RAD_SHIFT;
  localparam logic [PROD_W:0] RAD_ROUND = (PROD_W + 1)'(1) << (RAD_SHIFT - 1);
  localparam int STR_POS_MAX = (1 << (STR_W - 1)) - 1;
  localparam int STR_NEG_MAG = 1 << (STR_W - 1);

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_NRM_THR,
    MUL_NRM_RAT,
    MUL_NRM_STR,
    MUL_THR,
    MUL_ANG,
    MUL_RAD
  } mul_sel_e;

  typedef enum logic [1:0] {
    CORR_NONE,
    CORR_THR,
    CORR_RAT,
    CORR_STR
  } corr_sel_e;

  typedef struct packed {
    logic      load;
    mul_sel_e  mul;
    corr_sel_e corr;
    logic      thr_fin;
    logic      clamp;
    logic      out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic skip;
    logic out_free;
  } dp_stat_t;

  // Clamp a raw channel to the valid stick range and centre it.
  function automatic logic signed [D_W-1:0] centre_of(input logic [CHANNEL_BITS-1:0] raw);
    logic [CHANNEL_BITS-1:0] c;
    logic [D_W:0]            t;
    c = raw;
    if (c > CHANNEL_BITS'(CH_MAX)) c = CHANNEL_BITS'(CH_MAX);
    if (c < CHANNEL_BITS'(CH_MIN)) c = CHANNEL_BITS'(CH_MIN);
    t = {1'b0, c[D_W-1:0]} - (D_W + 1)'(CH_MID);
    return t[D_W-1:0];
  endfunction

  function automatic logic [MODE_W-1:0] mode_of(input logic signed [D_W-1:0] d);
    logic [MODE_W-1:0] m;
    if (d < D_MODE_LO) m = MODE_AUTO;
    else if (d > D_MODE_HI) m = MODE_MANUAL;
    else m = MODE_OVERRIDE;
    return m;
  endfunction

  function automatic logic in_band(input logic signed [D_W-1:0] d);
    return (d >= D_BAND_LO) && (d <= D_BAND_HI);
  endfunction

  // Dividend of the normalization: |d| * 32768 plus the rounding bias.
  function automatic logic [NUM_W-1:0] norm_num(input logic signed [D_W-1:0] d);
    logic [D_W-1:0] neg_d;
    logic [D_W-2:0] mag;
    neg_d = -d;
    mag   = d[D_W-1] ? neg_d[D_W-2:0] : d[D_W-2:0];
    return {mag, {Q_FRAC{1'b0}}} + (d[D_W-1] ? NUM_W'(BIAS_NEG) : NUM_W'(BIAS_POS));
  endfunction

  function automatic logic [MUL_B_W-1:0] norm_recip(input logic signed [D_W-1:0] d);
    return d[D_W-1] ? MUL_B_W'(RECIP_NEG) : MUL_B_W'(RECIP_POS);
  endfunction

  // The reciprocal estimate is low by at most one; fix it, apply sign and saturate.
  function automatic logic signed [N_W-1:0] norm_fix(input logic signed [D_W-1:0] d,
                                                     input logic [PROD_W-1:0]   p);
    logic [NUM_W-1:0] num;
    logic [D_W-2:0]   div;
    logic [Q_W-1:0]   q;
    logic [Q_W-1:0]   qn;
    logic [NUM_W+1:0] qd;
    logic [NUM_W+1:0] rem;
    logic [N_W-1:0]   n;
    num = norm_num(d);
    div = d[D_W-1] ? (D_W - 1)'(DIV_NEG) : (D_W - 1)'(DIV_POS);
    q   = p[RECIP_SHIFT +: Q_W];
    qd  = (NUM_W + 2)'(q) * (NUM_W + 2)'(div);
    rem = (NUM_W + 2)'(num) - qd;
    if (rem >= (NUM_W + 2)'(div)) q = q + 1'b1;
    qn = -q;
    if (d[D_W-1]) n = qn[N_W-1:0];
    else if (q > Q_W'((1 << (N_W - 1)) - 1)) n = N_W'((1 << (N_W - 1)) - 1);
    else n = q[N_W-1:0];
    return n;
  endfunction

  function automatic logic [MAG_W-1:0] mag_of(input logic signed [N_W-1:0] n);
    logic [MAG_W-1:0] e;
    e = {n[N_W-1], n};
    return n[N_W-1] ? -e : e;
  endfunction

endpackage

FILE: rtl/core/rcdc_ctrl.sv
module rcdc_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_valid_i,
  output logic               s_ready_o,
  input  rcdc_pkg::dp_stat_t stat_i,
  output rcdc_pkg::dp_cmd_t  cmd_o
);
  import rcdc_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_NRM_THR,
    ST_NRM_RAT,
    ST_NRM_STR,
    ST_THR_MUL,
    ST_ANG_MUL,
    ST_ANG_CLAMP,
    ST_RAD_MUL,
    ST_FIN
  } state_e;

  state_e state_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      case (state_q)
        ST_IDLE:      if (s_valid_i) state_q <= ST_NRM_THR;
        ST_NRM_THR:   state_q <= stat_i.skip ? ST_FIN : ST_NRM_RAT;
        ST_NRM_RAT:   state_q <= ST_NRM_STR;
        ST_NRM_STR:   state_q <= ST_THR_MUL;
        ST_THR_MUL:   state_q <= ST_ANG_MUL;
        ST_ANG_MUL:   state_q <= ST_ANG_CLAMP;
        ST_ANG_CLAMP: state_q <= ST_RAD_MUL;
        ST_RAD_MUL:   state_q <= ST_FIN;
        ST_FIN:       if (stat_i.out_free) state_q <= ST_IDLE;
        default:      state_q <= ST_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd_o          = '0;
    cmd_o.mul      = MUL_NONE;
    cmd_o.corr     = CORR_NONE;
    s_ready_o      = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_ready_o  = 1'b1;
        cmd_o.load = s_valid_i;
      end
      ST_NRM_THR: cmd_o.mul = MUL_NRM_THR;
      ST_NRM_RAT: begin
        cmd_o.mul  = MUL_NRM_RAT;
        cmd_o.corr = CORR_THR;
      end
      ST_NRM_STR: begin
        cmd_o.mul  = MUL_NRM_STR;
        cmd_o.corr = CORR_RAT;
      end
      ST_THR_MUL: begin
        cmd_o.mul  = MUL_THR;
        cmd_o.corr = CORR_STR;
      end
      ST_ANG_MUL: begin
        cmd_o.mul     = MUL_ANG;
        cmd_o.thr_fin = 1'b1;
      end
      ST_ANG_CLAMP: cmd_o.clamp = 1'b1;
      ST_RAD_MUL:   cmd_o.mul = MUL_RAD;
      ST_FIN:       cmd_o.out_load = stat_i.out_free;
      default: ;
    endcase
  end

`ifndef ASSERT_OFF
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_valid_i && s_ready_o) |=> (state_q == ST_NRM_THR))
    else $error("accepted frame did not start normalization");

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> stat_i.out_free)
    else $error("output register loaded while still occupied");
`endif

endmodule

FILE: rtl/core/rcdc_dp.sv
module rcdc_dp (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic [rcdc_pkg::S_TDATA_W-1:0]        s_tdata_i,
  input  rcdc_pkg::dp_cmd_t                     cmd_i,
  output rcdc_pkg::dp_stat_t                    stat_o,
  input  logic [rcdc_pkg::MAX_STEER_W-1:0]      max_steer_i,
  input  logic signed [rcdc_pkg::MIN_STEER_W-1:0] min_steer_i,
  input  logic [rcdc_pkg::BRAKE_W-1:0]          e_brake_i,
  output logic                                  m_tvalid_o,
  input  logic                                  m_tready_i,
  output logic [rcdc_pkg::M_TDATA_W-1:0]        m_tdata_o
);
  import rcdc_pkg::*;

  logic signed [D_W-1:0] d_thr_q, d_str_q, d_rat_q;
  logic signed [D_W-1:0] d_thr_in, d_str_in, d_rat_in, d_sl_in, d_sr_in, d_mode_in;
  logic                  emerg_q, centred_q;
  logic [MODE_W-1:0]     mode_new_q, held_q;

  logic [MUL_A_W-1:0]    mul_a;
  logic [MUL_B_W-1:0]    mul_b;
  logic [PROD_W-1:0]     prod, p_q;

  logic signed [N_W-1:0] n_thr_q, n_rat_q, n_str_q;
  logic signed [THR_W-1:0] thr_q, thr_d;
  logic                  ang_neg_q;
  logic [MUL_A_W-1:0]    ang_mag_q, ang_mag_d;
  logic                  ang_dz_q, ang_dz_d, ang_neg_d;
  logic [STR_W-1:0]      str_d;

  logic                  out_valid_q;
  logic [THR_W-1:0]      out_thr_q;
  logic [STR_W-1:0]      out_str_q;
  logic [BRAKE_W-1:0]    out_brake_q;
  logic                  out_act_q;
  logic [MODE_W-1:0]     out_mode_q;

  assign d_thr_in  = centre_of(s_tdata_i[CH_THR*CHANNEL_BITS +: CHANNEL_BITS]);
  assign d_str_in  = centre_of(s_tdata_i[CH_STR*CHANNEL_BITS +: CHANNEL_BITS]);
  assign d_rat_in  = centre_of(s_tdata_i[CH_RAT*CHANNEL_BITS +: CHANNEL_BITS]);
  assign d_sl_in   = centre_of(s_tdata_i[CH_SL*CHANNEL_BITS +: CHANNEL_BITS]);
  assign d_sr_in   = centre_of(s_tdata_i[CH_SR*CHANNEL_BITS +: CHANNEL_BITS]);
  assign d_mode_in = centre_of(s_tdata_i[CH_MODE*CHANNEL_BITS +: CHANNEL_BITS]);

  // Operand selection for the single shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.mul)
      MUL_NRM_THR: begin
        mul_a = MUL_A_W'(norm_num(d_thr_q));
        mul_b = norm_recip(d_thr_q);
      end
      MUL_NRM_RAT: begin
        mul_a = MUL_A_W'(norm_num(d_rat_q));
        mul_b = norm_recip(d_rat_q);
      end
      MUL_NRM_STR: begin
        mul_a = MUL_A_W'(norm_num(d_str_q));
        mul_b = norm_recip(d_str_q);
      end
      MUL_THR: begin
        // The ratio dial is offset to an unsigned 0..65535 scale.
        mul_a = MUL_A_W'(mag_of(n_thr_q));
        mul_b = MUL_B_W'({~n_rat_q[N_W-1], n_rat_q[N_W-2:0]});
      end
      MUL_ANG: begin
        mul_a = MUL_A_W'(mag_of(n_str_q));
        mul_b = n_str_q[N_W-1] ? MUL_B_W'(mag_of(min_steer_i)) : MUL_B_W'(max_steer_i);
      end
      MUL_RAD: begin
        mul_a = ang_mag_q;
        mul_b = MUL_B_W'(DEG2RAD_K);
      end
      default: ;
    endcase
  end

  assign prod = PROD_W'(mul_a) * PROD_W'(mul_b);

  // Throttle: round the scaled magnitude, then restore the sign.
  logic [THR_W+16:0] thr_sum;
  logic [Q_W-1:0]    thr_mag, thr_neg;
  always_comb begin
    thr_sum = (THR_W + 17)'(p_q[31:0]) + (THR_W + 17)'(32768);
    thr_mag = thr_sum[THR_W+16:16];
    thr_neg = -thr_mag;
    thr_d   = n_thr_q[N_W-1] ? thr_neg[THR_W-1:0] : thr_mag[THR_W-1:0];
  end

  // Angle limits, then the dead zone of a tenth of a degree.
  logic signed [ANG_W-1:0] a_raw, a_hi, a_lo, a_h, a_c, a_abs;
  logic [X10_W-1:0]        a_x10;
  always_comb begin
    a_raw     = $signed({2'b00, p_q[MUL_A_W-1:0]});
    if (ang_neg_q) a_raw = -a_raw;
    a_hi      = $signed({3'b000, max_steer_i, {Q_FRAC{1'b0}}});
    a_lo      = $signed({{2{min_steer_i[MIN_STEER_W-1]}}, min_steer_i, {Q_FRAC{1'b0}}});
    a_h       = (a_raw > a_hi) ? a_hi : a_raw;
    a_c       = (a_h < a_lo) ? a_lo : a_h;
    a_abs     = a_c[ANG_W-1] ? -a_c : a_c;
    ang_mag_d = a_abs[MUL_A_W-1:0];
    ang_neg_d = a_c[ANG_W-1];
    a_x10     = X10_W'({ang_mag_d, 3'b000}) + X10_W'({ang_mag_d, 1'b0});
    ang_dz_d  = a_x10 < X10_W'(DZ_LIMIT);
  end

  // Radians: round half away from zero and saturate to the field.
  logic [PROD_W:0] rad_sum;
  logic [RQ_W-1:0] rad_q, rad_neg;
  always_comb begin
    rad_sum = {1'b0, p_q} + RAD_ROUND;
    rad_q   = rad_sum[PROD_W:RAD_SHIFT];
    rad_neg = -rad_q;
    if (ang_dz_q) begin
      str_d = '0;
    end else if (ang_neg_q) begin
      str_d = (rad_q > RQ_W'(STR_NEG_MAG)) ? STR_W'(STR_NEG_MAG) : rad_neg[STR_W-1:0];
    end else begin
      str_d = (rad_q > RQ_W'(STR_POS_MAX)) ? STR_W'(STR_POS_MAX) : rad_q[STR_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      d_thr_q    <= d_thr_in;
      d_str_q    <= d_str_in;
      d_rat_q    <= d_rat_in;
      mode_new_q <= mode_of(d_mode_in);
    end
    if (cmd_i.mul != MUL_NONE) p_q <= prod;
    case (cmd_i.corr)
      CORR_THR: n_thr_q <= norm_fix(d_thr_q, p_q);
      CORR_RAT: n_rat_q <= norm_fix(d_rat_q, p_q);
      CORR_STR: n_str_q <= norm_fix(d_str_q, p_q);
      default: ;
    endcase
    if (cmd_i.mul == MUL_ANG) ang_neg_q <= n_str_q[N_W-1] && min_steer_i[MIN_STEER_W-1];
    if (cmd_i.thr_fin) thr_q <= thr_d;
    if (cmd_i.clamp) begin
      ang_mag_q <= ang_mag_d;
      ang_neg_q <= ang_neg_d;
      ang_dz_q  <= ang_dz_d;
    end
    if (cmd_i.out_load) begin
      if (emerg_q) begin
        out_thr_q   <= '0;
        out_str_q   <= '0;
        out_brake_q <= e_brake_i;
        out_act_q   <= 1'b0;
        out_mode_q  <= held_q;
      end else begin
        out_thr_q   <= centred_q ? '0 : thr_q;
        out_str_q   <= centred_q ? '0 : str_d;
        out_brake_q <= '0;
        out_act_q   <= 1'b1;
        out_mode_q  <= mode_new_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      emerg_q     <= 1'b0;
      centred_q   <= 1'b0;
      held_q      <= MODE_AUTO;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        // A stop switch at or above centre engages the emergency stop.
        emerg_q   <= !d_sl_in[D_W-1] || !d_sr_in[D_W-1];
        centred_q <= in_band(d_thr_in) && in_band(d_str_in);
      end
      if (cmd_i.out_load && !emerg_q) held_q <= mode_new_q;
      if (cmd_i.out_load) out_valid_q <= 1'b1;
      else if (m_tready_i) out_valid_q <= 1'b0;
    end
  end

  assign stat_o.skip     = emerg_q || centred_q;
  assign stat_o.out_free = !out_valid_q || m_tready_i;

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = {{(M_TDATA_W - M_FIELDS_W){1'b0}},
                       out_mode_q, out_act_q, out_brake_q, out_str_q, out_thr_q};

`ifndef ASSERT_OFF
  a_emerg_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.out_load && emerg_q) |=>
      (out_thr_q == '0 && out_str_q == '0 && !out_act_q && out_mode_q == held_q))
    else $error("emergency stop result is not a safe command");

  a_mode_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.out_load && !emerg_q) |=> (held_q == out_mode_q))
    else $error("held mode does not follow the mode given");

  a_steer_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_str_q != '0) |-> out_act_q)
    else $error("nonzero steering given while inactive");
`endif

endmodule

FILE: rtl/core/rc_channels_to_drive_command_unit.sv
// Translates one received radio frame of six channel values into one drive command.
// Each frame is a single transaction on the slave stream; the matching command leaves
// as a single transaction on the master stream, in order. A frame with either stick
// moved and no emergency stop makes six passes through one shared 31x27 multiplier
// (three normalizations, throttle scaling, wheel angle and radian conversion) plus an
// angle clamp step and the output load. A frame in emergency stop or with both sticks
// near centre goes from the throttle normalization straight to the output load, which
// waits for a free output register. The controller then returns to idle, where it takes
// the next frame, so no new frame is taken while one is in progress. The result sits in
// an output register, so the next frame is accepted while a result waits to be taken.
// Registers (APB, byte address 4*i): 0 max_steer_deg, 1 min_steer_deg, 2 emergency_brake.
module rc_channels_to_drive_command_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // APB configuration port
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [rcdc_pkg::PADDR_W-1:0]     paddr,
  input  logic [rcdc_pkg::PDATA_W-1:0]     pwdata,
  output logic [rcdc_pkg::PDATA_W-1:0]     prdata,
  output logic                             pready,
  // Channel frames
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // tdata: throttle_channel, steering_channel, ratio_channel, stop_left_channel,
  //        stop_right_channel, mode_channel, zero fill
  input  logic [rcdc_pkg::S_TDATA_W-1:0]   s_axis_tdata_i,
  // Drive commands
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // tdata: throttle_cmd[15:0], steering_cmd[33:16], brake_cmd[49:34], drive_active[50],
  //        drive_mode[52:51], zero fill
  output logic [rcdc_pkg::M_TDATA_W-1:0]   m_axis_tdata_o
);
  import rcdc_pkg::*;

  logic [MAX_STEER_W-1:0]        max_steer_q;
  logic signed [MIN_STEER_W-1:0] min_steer_q;
  logic [BRAKE_W-1:0]            e_brake_q;
  logic [1:0]                    reg_idx;
  logic                          cfg_wr;
  dp_cmd_t                       cmd;
  dp_stat_t                      stat;

  assign pready  = 1'b1;
  assign reg_idx = paddr[PADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_steer_q <= MAX_STEER_RST;
      min_steer_q <= MIN_STEER_RST;
      e_brake_q   <= E_BRAKE_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_MAX_STEER: max_steer_q <= pwdata[MAX_STEER_W-1:0];
        REG_MIN_STEER: min_steer_q <= pwdata[MIN_STEER_W-1:0];
        REG_E_BRAKE:   e_brake_q   <= pwdata[BRAKE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_MAX_STEER: prdata = PDATA_W'(max_steer_q);
      REG_MIN_STEER: prdata = PDATA_W'(min_steer_q);
      REG_E_BRAKE:   prdata = PDATA_W'(e_brake_q);
      default:       prdata = '0;
    endcase
  end

  rcdc_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_ready_o (s_axis_tready_o),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  rcdc_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tdata_i   (s_axis_tdata_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .max_steer_i (max_steer_q),
    .min_steer_i (min_steer_q),
    .e_brake_i   (e_brake_q),
    .m_tvalid_o  (m_axis_tvalid_o),
    .m_tready_i  (m_axis_tready_i),
    .m_tdata_o   (m_axis_tdata_o)
  );

endmodule

FILE: tb/sv/tb_rc_channels_to_drive_command_unit.sv
`timescale 1ns / 100ps

module tb_rc_channels_to_drive_command_unit;
  import rcdc_pkg::*;

  localparam int CW             = CHANNEL_BITS;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int LONG_HOLD      = 300;
  localparam int DRAIN_CYCLES   = 20;
  localparam logic [1:0] REG_UNUSED = 2'd3;

  // Raw values that park an emergency switch in the run or the stop position.
  localparam logic [CW-1:0] SW_RUN  = CW'(174);
  localparam logic [CW-1:0] SW_STOP = CW'(992);

  typedef struct packed {
    logic [CW-1:0] mode;
    logic [CW-1:0] stop_r;
    logic [CW-1:0] stop_l;
    logic [CW-1:0] ratio;
    logic [CW-1:0] steer;
    logic [CW-1:0] thr;
  } frame_t;

  typedef struct packed {
    logic [M_TDATA_W-M_FIELDS_W-1:0] fill;
    logic [MODE_W-1:0]               mode;
    logic                            active;
    logic [BRAKE_W-1:0]              brake;
    logic signed [STR_W-1:0]         steering;
    logic signed [THR_W-1:0]         throttle;
  } cmd_t;

  typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PATTERN} rx_stall_e;

  class drive_cmd_checker;
    logic [MAX_STEER_W-1:0]        max_steer;
    logic signed [MIN_STEER_W-1:0] min_steer;
    logic [BRAKE_W-1:0]            e_brake;
    logic [MODE_W-1:0]             held_mode;
    cmd_t                          expected_cmds[$];
    int                            errors;

    function new();
      max_steer = 15'd6400;
      min_steer = -16'sd6400;
      e_brake   = 16'hFFFF;
      held_mode = MODE_AUTO;
      errors    = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [PDATA_W-1:0] data);
      case (idx)
        REG_MAX_STEER: max_steer = data[MAX_STEER_W-1:0];
        REG_MIN_STEER: min_steer = data[MIN_STEER_W-1:0];
        REG_E_BRAKE:   e_brake = data[BRAKE_W-1:0];
        default: ;
      endcase
    endfunction

    function int centre(logic [CW-1:0] raw);
      int c;
      c = raw;
      if (c > CH_MAX) c = CH_MAX;
      if (c < CH_MIN) c = CH_MIN;
      return c - CH_MID;
    endfunction

    // Q1.15 with different spans above and below centre, rounded to nearest.
    function int normalize(int d);
      int v;
      if (d >= 0) begin
        v = (d * 32768 + 404) / 808;
        return (v > 32767) ? 32767 : v;
      end
      return -((-d * 32768 + 409) / 818);
    endfunction

    function logic [MODE_W-1:0] mode_from(int d);
      if (d < -409) return MODE_AUTO;
      if (d > 404) return MODE_MANUAL;
      return MODE_OVERRIDE;
    endfunction

    function int scale_throttle(int n_thr, int n_ratio);
      longint r;
      longint m;
      longint q;
      r = n_ratio + 32768;
      m = (n_thr < 0) ? -n_thr : n_thr;
      q = (m * r + 32768) >> 16;
      return (n_thr < 0) ? -int'(q) : int'(q);
    endfunction

    function int wheel_angle(int n);
      longint hi;
      longint lo;
      longint a;
      longint m;
      longint q;
      hi = longint'(max_steer) * 32768;
      lo = longint'(min_steer) * 32768;
      a = (n < 0) ? longint'(-n) * longint'(min_steer) : longint'(n) * longint'(max_steer);
      if (a > hi) a = hi;
      if (a < lo) a = lo;
      m = (a < 0) ? -a : a;
      // Angles under a tenth of a degree are treated as straight ahead.
      if (m * 10 < 64'sd8388608) return 0;
      q = (m * 64'sd74961321 + (64'sd1 << 38)) >> 39;
      if (a < 0) begin
        q = -q;
        if (q < -131072) q = -131072;
      end else if (q > 131071) begin
        q = 131071;
      end
      return int'(q);
    endfunction

    function cmd_t predict_command(frame_t f);
      cmd_t c;
      int   d_thr;
      int   d_str;
      c     = '0;
      d_thr = centre(f.thr);
      d_str = centre(f.steer);
      if (centre(f.stop_l) >= 0 || centre(f.stop_r) >= 0) begin
        c.brake = e_brake;
        c.mode  = held_mode;
        return c;
      end
      held_mode = mode_from(centre(f.mode));
      if (!(d_thr <= 40 && d_thr >= -40 && d_str <= 40 && d_str >= -40)) begin
        c.throttle = THR_W'(scale_throttle(normalize(d_thr), normalize(centre(f.ratio))));
        c.steering = STR_W'(wheel_angle(normalize(d_str)));
      end
      c.active = 1'b1;
      c.mode   = held_mode;
      return c;
    endfunction

    function void note_frame(frame_t f);
      expected_cmds.push_back(predict_command(f));
    endfunction

    function void check_cmd(cmd_t got);
      cmd_t exp_c;
      if (expected_cmds.size() == 0) begin
        $error("drive command with no frame waiting: %h", got);
        errors++;
        return;
      end
      exp_c = expected_cmds.pop_front();
      if (got.throttle !== exp_c.throttle) begin
        $error("throttle_cmd: expected %0d, got %0d", exp_c.throttle, got.throttle);
        errors++;
      end
      if (got.steering !== exp_c.steering) begin
        $error("steering_cmd: expected %0d, got %0d", exp_c.steering, got.steering);
        errors++;
      end
      if (got.brake !== exp_c.brake) begin
        $error("brake_cmd: expected %0d, got %0d", exp_c.brake, got.brake);
        errors++;
      end
      if (got.active !== exp_c.active) begin
        $error("drive_active: expected %0d, got %0d", exp_c.active, got.active);
        errors++;
      end
      if (got.mode !== exp_c.mode) begin
        $error("drive_mode: expected %0d, got %0d", exp_c.mode, got.mode);
        errors++;
      end
    endfunction

    function int outstanding();
      return expected_cmds.size();
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [PADDR_W-1:0]   paddr = '0;
  logic [PDATA_W-1:0]   pwdata = '0;
  logic [PDATA_W-1:0]   prdata;
  logic                 pready;
  logic                 s_axis_tvalid_i = 1'b0;
  logic                 s_axis_tready_o;
  logic [S_TDATA_W-1:0] s_axis_tdata_i = '0;
  logic                 m_axis_tvalid_o;
  logic                 m_axis_tready_i = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata_o;

  drive_cmd_checker sb;
  rx_stall_e        stall_mode = RX_ALWAYS;
  int               hold_tag = 0;
  int               hold_seen = 0;
  int               hold_left = 0;
  logic [2:0]       rx_phase = '0;
  int               idle_cycles = 0;
  int               burst_left = 0;

  rc_channels_to_drive_command_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  always #5 clk_i = ~clk_i;

  // Command sink: a long hold-off on request, otherwise the current stall pattern.
  always @(posedge clk_i) begin
    rx_phase <= rx_phase + 1'b1;
    if (hold_tag != hold_seen) begin
      hold_seen       <= hold_tag;
      hold_left       <= LONG_HOLD;
      m_axis_tready_i <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left       <= hold_left - 1;
      m_axis_tready_i <= 1'b0;
    end else begin
      case (stall_mode)
        RX_ALWAYS:  m_axis_tready_i <= 1'b1;
        RX_RANDOM:  m_axis_tready_i <= ($urandom_range(0, 2) != 0);
        default:    m_axis_tready_i <= (rx_phase < 3'd3);
      endcase
    end
  end

  always @(posedge clk_i) begin
    logic took_in;
    logic took_out;
    took_in  = rst_ni && s_axis_tvalid_i && s_axis_tready_o;
    took_out = rst_ni && m_axis_tvalid_o && m_axis_tready_i;
    if (took_in) sb.note_frame(frame_t'(s_axis_tdata_i[$bits(frame_t)-1:0]));
    if (took_out) sb.check_cmd(cmd_t'(m_axis_tdata_o));
    if (!rst_ni || took_in || took_out) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("tb_rc_channels_to_drive_command_unit: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic apb_write(input logic [1:0] idx, input logic [PDATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.write_reg(idx, value);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  // Upper bits beyond each register's width carry random junk.
  task automatic set_steer_and_brake(input int max_deg, input int min_deg, input int brake);
    apb_write(REG_MAX_STEER, ($urandom() << MAX_STEER_W) | PDATA_W'(max_deg & 16'h7FFF));
    apb_write(REG_MIN_STEER, ($urandom() << MIN_STEER_W) | PDATA_W'(min_deg & 16'hFFFF));
    apb_write(REG_E_BRAKE, ($urandom() << BRAKE_W) | PDATA_W'(brake & 16'hFFFF));
  endtask

  task automatic send_frame(input frame_t f);
    s_axis_tdata_i  <= S_TDATA_W'(f);
    s_axis_tvalid_i <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready_o);
  endtask

  // Bursts of random length separated by random gaps; some bursts are long.
  task automatic pace_sender();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 14);
      if (gap != 0) begin
        s_axis_tvalid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.outstanding() != 0) @(posedge clk_i);
  endtask

  function automatic frame_t mk(input int thr, input int steer, input int ratio,
                                input int stop_l, input int stop_r, input int mode);
    frame_t f;
    f.thr    = CW'(thr);
    f.steer  = CW'(steer);
    f.ratio  = CW'(ratio);
    f.stop_l = CW'(stop_l);
    f.stop_r = CW'(stop_r);
    f.mode   = CW'(mode);
    return f;
  endfunction

  function automatic logic [CW-1:0] pick_channel();
    int corners[11] = '{0, 173, 174, 175, 991, 992, 993, 1799, 1800, 1801, 2047};
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return CW'($urandom_range(0, (1 << CW) - 1));
      4, 5, 6:    return CW'($urandom_range(CH_MIN, CH_MAX));
      7, 8:       return CW'($urandom_range(CH_MID - 44, CH_MID + 44));
      default:    return CW'(corners[$urandom_range(0, 10)]);
    endcase
  endfunction

  // Mostly armed frames so that the command path is exercised; stops stay common.
  function automatic logic [CW-1:0] pick_switch();
    if ($urandom_range(0, 99) < 85) return CW'($urandom_range(0, CH_MID - 1));
    return pick_channel();
  endfunction

  function automatic frame_t random_frame();
    frame_t f;
    f.thr    = pick_channel();
    f.steer  = pick_channel();
    f.ratio  = pick_channel();
    f.stop_l = pick_switch();
    f.stop_r = pick_switch();
    f.mode   = pick_channel();
    if ($urandom_range(0, 9) == 0) begin
      f.thr   = CW'($urandom_range(CH_MID - 40, CH_MID + 40));
      f.steer = CW'($urandom_range(CH_MID - 40, CH_MID + 40));
    end
    return f;
  endfunction

  task automatic run_phase(input int n_items, input rx_stall_e stall, input bit bursty);
    stall_mode <= stall;
    burst_left = 0;
    for (int i = 0; i < n_items; i++) begin
      send_frame(random_frame());
      if (bursty) pace_sender();
    end
    drain();
  endtask

  initial begin
    sb = new();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed frames at the reset settings.
    stall_mode <= RX_RANDOM;
    send_frame(mk(992, 992, 992, SW_RUN, SW_RUN, 0));
    send_frame(mk(2047, 2047, 2047, 0, 0, 2047));
    send_frame(mk(0, 0, 0, SW_RUN, SW_RUN, 1397));
    send_frame(mk(1800, 174, 1800, SW_RUN, SW_RUN, 1396));
    send_frame(mk(174, 1800, 992, SW_RUN, SW_RUN, 582));
    send_frame(mk(2047, 1200, 1500, SW_RUN, SW_RUN, 583));
    send_frame(mk(1800, 1800, 1800, SW_STOP, SW_RUN, 2047));
    send_frame(mk(1800, 1800, 1800, SW_RUN, 2047, 0));
    send_frame(mk(1800, 1800, 1800, 1800, 1801, 0));
    send_frame(mk(1500, 700, 1300, 991, 991, 1397));
    send_frame(mk(600, 600, 600, SW_RUN, SW_STOP, 0));
    send_frame(mk(1032, 952, 2047, SW_RUN, SW_RUN, 992));
    send_frame(mk(1033, 992, 2047, SW_RUN, SW_RUN, 992));
    send_frame(mk(992, 951, 2047, SW_RUN, SW_RUN, 0));
    send_frame(mk(1800, 995, 1800, SW_RUN, SW_RUN, 2047));
    send_frame(mk(1800, 996, 1800, SW_RUN, SW_RUN, 2047));
    send_frame(mk(174, 989, 174, SW_RUN, SW_RUN, 2047));
    send_frame(mk(174, 988, 1800, SW_RUN, SW_RUN, 2047));
    send_frame(mk(1400, 1100, 992, SW_RUN, SW_RUN, 1200));
    send_frame(mk(500, 1700, 600, SW_RUN, SW_RUN, 2047));
    send_frame(mk(300, 300, 300, 2047, SW_RUN, 500));
    send_frame(mk(1000, 1800, 174, 173, 0, 992));
    drain();

    set_steer_and_brake(23040, -23040, 0);
    run_phase(135, RX_ALWAYS, 1'b0);

    set_steer_and_brake(0, 0, 1);
    run_phase(135, RX_RANDOM, 1'b1);

    // Widest registers; the sink holds off while frames keep coming.
    set_steer_and_brake(32767, -32768, 65535);
    run_phase(60, RX_PATTERN, 1'b1);
    hold_tag <= hold_tag + 1;
    for (int i = 0; i < 30; i++) send_frame(random_frame());
    drain();
    run_phase(75, RX_PATTERN, 1'b1);

    set_steer_and_brake($urandom_range(0, 23040), -$urandom_range(0, 23040),
                        $urandom_range(0, 65535));
    run_phase(135, RX_RANDOM, 1'b1);

    // A positive lower limit and a write to an address with no register.
    set_steer_and_brake(300, 5000, $urandom_range(0, 65535));
    apb_write(REG_UNUSED, $urandom());
    run_phase(135, RX_RANDOM, 1'b1);

    set_steer_and_brake(6400, -6400, 65535);
    run_phase(135, RX_PATTERN, 1'b1);

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.outstanding() != 0) begin
      $error("%0d drive commands never arrived", sb.outstanding());
    end
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("tb_rc_channels_to_drive_command_unit: clean");
    end else begin
      $display("tb_rc_channels_to_drive_command_unit: errors");
    end
    $finish;
  end

endmodule

FILE: rc_channels_to_drive_command_unit.f
rtl/core/rcdc_pkg.sv
rtl/core/rcdc_ctrl.sv
rtl/core/rcdc_dp.sv
rtl/core/rc_channels_to_drive_command_unit.sv
tb/sv/tb_rc_channels_to_drive_command_unit.sv
